// ===== design/cosine_topk_vector_index_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cosine top-k vector index.
// Every check is clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COSINE_TOPK_VECTOR_INDEX_TOP_MACROS_SVH
`define COSINE_TOPK_VECTOR_INDEX_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CTVI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CTVI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CTVI_ASSERT(lbl, prop, msg)
`define CTVI_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/ctvi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctvi_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ctvi_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_MAX_LENGTH    = 256;
  localparam int DEF_TOP_LIMIT     = 16;

  localparam int VLEN_W     = 9;
  localparam int VLEN_RESET = 256;
  localparam int ID_W       = 64;
  localparam int ELEM_W     = 16;
  localparam int SCORE_W    = 16;
  localparam int LIMIT_W    = 5;
  localparam int STATUS_W   = 3;
  localparam int NORM_FLOOR = 11;
  localparam int ROOT_SHIFT = 30;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADDED     = 3'd0,
    STS_WRONG_LEN = 3'd1,
    STS_FULL      = 3'd2,
    STS_REMOVED   = 3'd3,
    STS_NOT_FOUND = 3'd4,
    STS_HIT       = 3'd5,
    STS_NO_HITS   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_D = 2'd1,
    MUL_T = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     latch;
    logic     elem_wr;
    logic     cnt_clr;
    logic     scan_clr;
    logic     scan_en;
    logic     rm_clear;
    logic     sel_slot;
    logic     copy_clr;
    logic     copy_en;
    logic     add_commit;
    logic     sr_init;
    logic     slot_next;
    logic     acc_clr;
    logic     acc_en;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     save_p;
    logic     save_r;
    logic     root_clr;
    logic     sq_en;
    logic     root_step;
    logic     ins_en;
    logic     k_next;
    logic     emit;
    status_t  code;
  } cmd_t;

  typedef struct packed {
    logic len_ok;
    logic scan_done;
    logic found;
    logic free_ok;
    logic copy_done;
    logic acc_done;
    logic score_zero;
    logic mul_done;
    logic root_last;
    logic slot_end;
    logic slot_vld;
    logic lim_zero;
    logic out_last;
  } sts_t;

  function automatic int clogm(input int x);
    return (x > 1) ? $clog2(x) : 1;
  endfunction

endpackage

// ===== design/ctvi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctvi_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ctvi_ram
  import ctvi_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = clogm(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ctvi_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctvi_mul
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ctvi_mul
  import ctvi_pkg::*;
#(
  parameter int A_W = 82,
  parameter int B_W = 41,
  localparam int P_W = A_W + B_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [P_W-1:0] p
);

  logic [P_W-1:0] a_r;
  logic [B_W-1:0] b_r;
  logic [P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else if (start) begin
      b_r <= b;
    end else if (b_r != '0) begin
      b_r <= b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= P_W'(a);
      p_r <= '0;
    end else if (b_r != '0) begin
      if (b_r[0]) begin
        p_r <= p_r + a_r;
      end
      a_r <= a_r << 1;
    end
  end

  assign done = (b_r == '0);
  assign p    = p_r;

endmodule

// ===== design/ctvi_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctvi_datapath
// Staging, vector store, id table, scoring arithmetic, top list and output.
// ----------------------------------------------------------------------------
`include "cosine_topk_vector_index_top_macros.svh"
module ctvi_datapath
  import ctvi_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int MAX_LENGTH    = DEF_MAX_LENGTH,
  parameter int TOP_LIMIT     = DEF_TOP_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [ID_W-1:0]     in_entry_id,
  input  logic [ELEM_W-1:0]   in_element_value,
  input  logic [LIMIT_W-1:0]  in_result_limit,
  input  logic                cfg_we,
  input  logic [VLEN_W-1:0]   cfg_wdata,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [ID_W-1:0]     out_result_id,
  output logic [SCORE_W-1:0]  out_similarity,
  output logic                out_final_result
);

  localparam int SW   = clogm(TABLE_ENTRIES);
  localparam int EA   = clogm(MAX_LENGTH);
  localparam int CW   = $clog2(MAX_LENGTH + 2);
  localparam int NW   = (CW > VLEN_W) ? CW : VLEN_W;
  localparam int ACW  = 32 + $clog2(MAX_LENGTH + 1);
  localparam int MAW  = 2 * ACW;
  localparam int MBW  = (ACW > 32) ? ACW : 32;
  localparam int PW   = MAW + MBW;
  localparam int KW   = clogm(TOP_LIMIT);
  localparam int LMW  = $clog2(TOP_LIMIT + 1);

  logic [VLEN_W-1:0] vlen_r;
  logic [CW-1:0]     cnt_r;
  logic [ID_W-1:0]   req_id_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [SW:0]   sc_r;
  logic          pend_r;
  logic [SW-1:0] pidx_r;
  logic          found_r;
  logic [SW-1:0] fslot_r;
  logic          freef_r;
  logic [SW-1:0] free_r;
  logic [SW-1:0] tgt_r;

  logic [EA:0]   cp_r;
  logic          cpend_r;
  logic [EA-1:0] cidx_r;

  logic [SW:0]   sp_r;
  logic [NW-1:0] ai_r;
  logic [NW-1:0] n_w;
  logic          v1_r;
  logic          v2_r;
  logic signed [31:0] pd_r;
  logic signed [31:0] pa_r;
  logic signed [31:0] pb_r;
  logic signed [ACW-1:0] dot_r;
  logic [ACW-1:0] na_r;
  logic [ACW-1:0] nb_r;

  logic [MAW-1:0] p_r;
  logic [PW-1:0]  rr_r;
  logic [15:0]    s_r;
  logic [3:0]     bit_r;
  logic [15:0]    cand_w;
  logic [31:0]    t_r;
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  logic           mul_done;
  logic [PW-1:0]  prod;

  logic [SCORE_W-1:0] bs_r   [TOP_LIMIT];
  logic [SW-1:0]      bsl_r  [TOP_LIMIT];
  logic [SCORE_W-1:0] bs_nxt [TOP_LIMIT];
  logic [SW-1:0]      bsl_nxt[TOP_LIMIT];
  logic [TOP_LIMIT-1:0] ge;
  logic [LMW-1:0] bcnt_r;
  logic [KW-1:0]  k_r;
  logic [LMW-1:0] lim_w;

  logic [ELEM_W-1:0] stage_q;
  logic [ELEM_W-1:0] store_q;
  logic [ID_W-1:0]   id_q;
  logic [EA-1:0]     stage_raddr;
  logic [SW-1:0]     id_raddr;

  logic                out_strobe_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [SCORE_W-1:0]  out_sim_r;
  logic                out_fin_r;

  assign stage_raddr = cmd.copy_en ? cp_r[EA-1:0] : ai_r[EA-1:0];
  assign id_raddr    = cmd.scan_en ? sc_r[SW-1:0] : bsl_r[k_r];

  ctvi_ram #(.WIDTH(ELEM_W), .DEPTH(2 ** EA)) u_stage (
    .clk   (clk),
    .we    (cmd.elem_wr && (32'(cnt_r) < MAX_LENGTH)),
    .waddr (cnt_r[EA-1:0]),
    .wdata (in_element_value),
    .raddr (stage_raddr),
    .rdata (stage_q)
  );

  ctvi_ram #(.WIDTH(ELEM_W), .DEPTH(2 ** (SW + EA))) u_store (
    .clk   (clk),
    .we    (cpend_r),
    .waddr ({tgt_r, cidx_r}),
    .wdata ((CW'(cidx_r) < cnt_r) ? stage_q : '0),
    .raddr ({sp_r[SW-1:0], ai_r[EA-1:0]}),
    .rdata (store_q)
  );

  ctvi_ram #(.WIDTH(ID_W), .DEPTH(2 ** SW)) u_ids (
    .clk   (clk),
    .we    (cmd.add_commit),
    .waddr (tgt_r),
    .wdata (req_id_r),
    .raddr (id_raddr),
    .rdata (id_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= VLEN_W'(VLEN_RESET);
    end else if (cfg_we) begin
      vlen_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.elem_wr && (32'(cnt_r) <= MAX_LENGTH)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_id_r <= in_entry_id;
      limit_r  <= in_result_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.rm_clear) begin
      valid_r[fslot_r] <= 1'b0;
    end else if (cmd.add_commit) begin
      valid_r[tgt_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r    <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      freef_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      sc_r    <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      freef_r <= 1'b0;
    end else if (cmd.scan_en) begin
      if (32'(sc_r) < TABLE_ENTRIES) begin
        sc_r <= sc_r + 1'b1;
      end
      pend_r <= (32'(sc_r) < TABLE_ENTRIES);
      if (pend_r) begin
        if (valid_r[pidx_r] && (id_q == req_id_r) && !found_r) begin
          found_r <= 1'b1;
        end
        if (!valid_r[pidx_r] && !freef_r) begin
          freef_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      pidx_r <= sc_r[SW-1:0];
      if (pend_r && valid_r[pidx_r] && (id_q == req_id_r) && !found_r) begin
        fslot_r <= pidx_r;
      end
      if (pend_r && !valid_r[pidx_r] && !freef_r) begin
        free_r <= pidx_r;
      end
    end
    if (cmd.sel_slot) begin
      tgt_r <= found_r ? fslot_r : free_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r    <= '0;
      cpend_r <= 1'b0;
    end else if (cmd.copy_clr) begin
      cp_r    <= '0;
      cpend_r <= 1'b0;
    end else if (cmd.copy_en) begin
      if (32'(cp_r) < MAX_LENGTH) begin
        cp_r <= cp_r + 1'b1;
      end
      cpend_r <= (32'(cp_r) < MAX_LENGTH);
    end else begin
      cpend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cidx_r <= cp_r[EA-1:0];
  end

  always_comb begin
    n_w = NW'(cnt_r);
    if (32'(n_w) > MAX_LENGTH) begin
      n_w = NW'(MAX_LENGTH);
    end
    if (n_w > NW'(vlen_r)) begin
      n_w = NW'(vlen_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.sr_init) begin
      sp_r <= '0;
    end else if (cmd.slot_next) begin
      sp_r <= sp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ai_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (cmd.acc_clr) begin
      ai_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (cmd.acc_en && (ai_r < n_w)) begin
        ai_r <= ai_r + 1'b1;
      end
      v1_r <= cmd.acc_en && (ai_r < n_w);
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pd_r <= $signed(stage_q) * $signed(store_q);
    pa_r <= $signed(stage_q) * $signed(stage_q);
    pb_r <= $signed(store_q) * $signed(store_q);
    if (cmd.acc_clr) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
    end else if (v2_r) begin
      dot_r <= dot_r + ACW'(pd_r);
      na_r  <= na_r + ACW'($unsigned(pa_r));
      nb_r  <= nb_r + ACW'($unsigned(pb_r));
    end
  end

  always_comb begin
    mul_a = p_r;
    mul_b = MBW'(t_r);
    unique case (cmd.mul_sel)
      MUL_P: begin
        mul_a = MAW'(na_r);
        mul_b = MBW'(nb_r);
      end
      MUL_D: begin
        mul_a = MAW'($unsigned(dot_r));
        mul_b = MBW'($unsigned(dot_r));
      end
      MUL_T: begin
        mul_a = p_r;
        mul_b = MBW'(t_r);
      end
      default: begin
        mul_a = p_r;
        mul_b = MBW'(t_r);
      end
    endcase
  end

  ctvi_mul #(.A_W(MAW), .B_W(MBW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (prod)
  );

  assign cand_w = s_r | (16'd1 << bit_r);

  always_ff @(posedge clk) begin
    if (cmd.save_p) begin
      p_r <= prod[MAW-1:0];
    end
    if (cmd.save_r) begin
      rr_r <= PW'({prod[MAW-1:0], {ROOT_SHIFT{1'b0}}});
    end
    if (cmd.sq_en) begin
      t_r <= cand_w * cand_w;
    end
    if (cmd.root_clr) begin
      s_r   <= '0;
      bit_r <= 4'd15;
    end else if (cmd.root_step) begin
      if (prod <= rr_r) begin
        s_r <= cand_w;
      end
      bit_r <= bit_r - 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j < TOP_LIMIT; j++) begin
      ge[j] = (32'(bcnt_r) > j) && (bs_r[j] >= s_r);
    end
    for (int j = 0; j < TOP_LIMIT; j++) begin
      if (ge[j]) begin
        bs_nxt[j]  = bs_r[j];
        bsl_nxt[j] = bsl_r[j];
      end else if (j == 0) begin
        bs_nxt[j]  = s_r;
        bsl_nxt[j] = sp_r[SW-1:0];
      end else if (ge[j-1]) begin
        bs_nxt[j]  = s_r;
        bsl_nxt[j] = sp_r[SW-1:0];
      end else begin
        bs_nxt[j]  = bs_r[j-1];
        bsl_nxt[j] = bsl_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_en && (s_r != '0)) begin
      for (int j = 0; j < TOP_LIMIT; j++) begin
        bs_r[j]  <= bs_nxt[j];
        bsl_r[j] <= bsl_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
      k_r    <= '0;
    end else if (cmd.sr_init) begin
      bcnt_r <= '0;
      k_r    <= '0;
    end else begin
      if (cmd.ins_en && (s_r != '0) && (32'(bcnt_r) < TOP_LIMIT)) begin
        bcnt_r <= bcnt_r + 1'b1;
      end
      if (cmd.k_next) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  assign lim_w = (32'(limit_r) < 32'(bcnt_r)) ? LMW'(limit_r) : bcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.code;
      if (cmd.code == STS_HIT) begin
        out_id_r  <= id_q;
        out_sim_r <= bs_r[k_r];
        out_fin_r <= sts.out_last;
      end else begin
        out_id_r  <= (cmd.code == STS_NO_HITS) ? '0 : req_id_r;
        out_sim_r <= '0;
        out_fin_r <= 1'b1;
      end
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_result_id    = out_id_r;
  assign out_similarity   = out_sim_r;
  assign out_final_result = out_fin_r;

  always_comb begin
    sts            = '0;
    sts.len_ok     = (NW'(cnt_r) == NW'(vlen_r)) && (32'(cnt_r) <= MAX_LENGTH) &&
                     (cnt_r != '0);
    sts.scan_done  = (32'(sc_r) == TABLE_ENTRIES) && !pend_r;
    sts.found      = found_r;
    sts.free_ok    = freef_r;
    sts.copy_done  = (32'(cp_r) == MAX_LENGTH) && !cpend_r;
    sts.acc_done   = (ai_r == n_w) && !v1_r && !v2_r;
    sts.score_zero = (n_w == '0) || (na_r < ACW'(NORM_FLOOR)) ||
                     (nb_r < ACW'(NORM_FLOOR)) || dot_r[ACW-1] || (dot_r == '0);
    sts.mul_done   = mul_done;
    sts.root_last  = (bit_r == '0);
    sts.slot_end   = (32'(sp_r) == TABLE_ENTRIES);
    sts.slot_vld   = valid_r[sp_r[SW-1:0]];
    sts.lim_zero   = (lim_w == '0);
    sts.out_last   = ((LMW + 1)'(k_r) + 1'b1) == (LMW + 1)'(lim_w);
  end

  `CTVI_ASSERT(a_strobe_gap, out_strobe_r |=> !out_strobe_r, "back-to-back result strobes")
  `CTVI_ASSERT(a_mul_idle, cmd.mul_start |-> mul_done, "multiplier restarted while busy")
  `CTVI_NEVER(a_top_count, 32'(bcnt_r) > TOP_LIMIT, "top list count overflow")

endmodule

// ===== design/ctvi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctvi_ctrl
// Sequencer for element intake, add, remove, search scoring and result output.
// ----------------------------------------------------------------------------
`include "cosine_topk_vector_index_top_macros.svh"
module ctvi_ctrl
  import ctvi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  logic       in_last_element,
  input  sts_t       sts,
  output cmd_t       cmd_o,
  output logic       busy
);

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_RM_SCAN  = 22'h000002,
    S_RM_DONE  = 22'h000004,
    S_ADD_CHK  = 22'h000008,
    S_ADD_SCAN = 22'h000010,
    S_ADD_SEL  = 22'h000020,
    S_ADD_COPY = 22'h000040,
    S_ADD_FIN  = 22'h000080,
    S_SR_INIT  = 22'h000100,
    S_SR_SEL   = 22'h000200,
    S_SR_ACC   = 22'h000400,
    S_SR_CHK   = 22'h000800,
    S_MUL_P    = 22'h001000,
    S_START_D  = 22'h002000,
    S_MUL_D    = 22'h004000,
    S_RT_SQ    = 22'h008000,
    S_RT_ST    = 22'h010000,
    S_RT_MUL   = 22'h020000,
    S_SR_INS   = 22'h040000,
    S_OUT      = 22'h080000,
    S_OUT_RD   = 22'h100000,
    S_OUT_EM   = 22'h200000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  cmd_t   cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (in_mode == MODE_REMOVE) begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_RM_SCAN;
          end else if ((in_mode == MODE_ADD) || (in_mode == MODE_SEARCH)) begin
            cmd.elem_wr = 1'b1;
            if (in_last_element) begin
              state_nxt = (in_mode == MODE_ADD) ? S_ADD_CHK : S_SR_INIT;
            end
          end
        end
      end
      S_RM_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_RM_DONE;
        end
      end
      S_RM_DONE: begin
        cmd.emit     = 1'b1;
        cmd.rm_clear = sts.found;
        cmd.code     = sts.found ? STS_REMOVED : STS_NOT_FOUND;
        state_nxt    = S_IDLE;
      end
      S_ADD_CHK: begin
        if (!sts.len_ok) begin
          cmd.emit    = 1'b1;
          cmd.code    = STS_WRONG_LEN;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_ADD_SCAN;
        end
      end
      S_ADD_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_ADD_SEL;
        end
      end
      S_ADD_SEL: begin
        if (sts.found || sts.free_ok) begin
          cmd.sel_slot = 1'b1;
          cmd.copy_clr = 1'b1;
          state_nxt    = S_ADD_COPY;
        end else begin
          cmd.emit    = 1'b1;
          cmd.code    = STS_FULL;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_ADD_COPY: begin
        cmd.copy_en = 1'b1;
        if (sts.copy_done) begin
          state_nxt = S_ADD_FIN;
        end
      end
      S_ADD_FIN: begin
        cmd.add_commit = 1'b1;
        cmd.emit       = 1'b1;
        cmd.code       = STS_ADDED;
        cmd.cnt_clr    = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_SR_INIT: begin
        cmd.sr_init = 1'b1;
        state_nxt   = S_SR_SEL;
      end
      S_SR_SEL: begin
        if (sts.slot_end) begin
          state_nxt = S_OUT;
        end else if (!sts.slot_vld) begin
          cmd.slot_next = 1'b1;
        end else begin
          cmd.acc_clr = 1'b1;
          state_nxt   = S_SR_ACC;
        end
      end
      S_SR_ACC: begin
        cmd.acc_en = 1'b1;
        if (sts.acc_done) begin
          state_nxt = S_SR_CHK;
        end
      end
      S_SR_CHK: begin
        if (sts.score_zero) begin
          cmd.slot_next = 1'b1;
          state_nxt     = S_SR_SEL;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_P;
          state_nxt     = S_MUL_P;
        end
      end
      S_MUL_P: begin
        if (sts.mul_done) begin
          cmd.save_p = 1'b1;
          state_nxt  = S_START_D;
        end
      end
      S_START_D: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_D;
        state_nxt     = S_MUL_D;
      end
      S_MUL_D: begin
        if (sts.mul_done) begin
          cmd.save_r   = 1'b1;
          cmd.root_clr = 1'b1;
          state_nxt    = S_RT_SQ;
        end
      end
      S_RT_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_RT_ST;
      end
      S_RT_ST: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_T;
        state_nxt     = S_RT_MUL;
      end
      S_RT_MUL: begin
        cmd.mul_sel = MUL_T;
        if (sts.mul_done) begin
          cmd.root_step = 1'b1;
          state_nxt     = sts.root_last ? S_SR_INS : S_RT_SQ;
        end
      end
      S_SR_INS: begin
        cmd.ins_en    = 1'b1;
        cmd.slot_next = 1'b1;
        state_nxt     = S_SR_SEL;
      end
      S_OUT: begin
        if (sts.lim_zero) begin
          cmd.emit    = 1'b1;
          cmd.code    = STS_NO_HITS;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_EM;
      end
      S_OUT_EM: begin
        cmd.emit   = 1'b1;
        cmd.code   = STS_HIT;
        cmd.k_next = 1'b1;
        if (sts.out_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;
  assign busy  = (state_r != S_IDLE);

  `CTVI_ASSERT(a_rm_busy, (start && !busy && in_mode == MODE_REMOVE) |=> busy, "remove not taken")
  `CTVI_NEVER(a_elem_busy, busy && cmd.elem_wr, "element written while busy")
  `CTVI_NEVER(a_commit_clear, cmd.add_commit && cmd.rm_clear, "commit and clear together")

endmodule

// ===== design/cosine_topk_vector_index_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_topk_vector_index_top
// Id-tagged vector table searched by cosine similarity with ranked results.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | start, busy        | in_mode, in_entry_id, in_element_value,
//           |                    | in_last_element, in_result_limit
//  result   | out_strobe         | out_status, out_result_id,
//           |                    | out_similarity, out_final_result
//  config   | cfg_we             | cfg_wdata (vector_length)
//
// A search walks every slot; each valid slot is accumulated over the vector
// length, and a scored slot then uses the shift-and-add multiplier to form
// the norms and the square root bits. Each hit is read from the id table
// read port before it is emitted.
// Reset is synchronous; no clearing pass is needed. Results cannot be stalled.
// ----------------------------------------------------------------------------
module cosine_topk_vector_index_top
  import ctvi_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int MAX_LENGTH    = DEF_MAX_LENGTH,
  parameter int TOP_LIMIT     = DEF_TOP_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [ID_W-1:0]     in_entry_id,
  input  logic [ELEM_W-1:0]   in_element_value,
  input  logic                in_last_element,
  input  logic [LIMIT_W-1:0]  in_result_limit,
  input  logic                cfg_we,
  input  logic [VLEN_W-1:0]   cfg_wdata,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [ID_W-1:0]     out_result_id,
  output logic [SCORE_W-1:0]  out_similarity,
  output logic                out_final_result
);

  cmd_t cmd;
  sts_t sts;

  ctvi_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_mode         (in_mode),
    .in_last_element (in_last_element),
    .sts             (sts),
    .cmd_o           (cmd),
    .busy            (busy)
  );

  ctvi_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_LENGTH    (MAX_LENGTH),
    .TOP_LIMIT     (TOP_LIMIT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_entry_id      (in_entry_id),
    .in_element_value (in_element_value),
    .in_result_limit  (in_result_limit),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_result_id    (out_result_id),
    .out_similarity   (out_similarity),
    .out_final_result (out_final_result)
  );

endmodule

// ===== tb/sv/cosine_topk_vector_index_top_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_topk_vector_index_top_checker
// Watches the input, result and configuration channels of the vector index,
// keeps its own copy of the table and staging buffer, predicts the results
// of every accepted transaction and compares them in order, field by field.
// ----------------------------------------------------------------------------
module cosine_topk_vector_index_top_checker
  import ctvi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [ID_W-1:0]     in_entry_id,
  input  logic [ELEM_W-1:0]   in_element_value,
  input  logic                in_last_element,
  input  logic [LIMIT_W-1:0]  in_result_limit,
  input  logic                cfg_we,
  input  logic [VLEN_W-1:0]   cfg_wdata,
  input  logic                out_strobe,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [ID_W-1:0]     out_result_id,
  input  logic [SCORE_W-1:0]  out_similarity,
  input  logic                out_final_result,
  output int                  errors,
  output int                  pending
);

  localparam int ENTRIES = DEF_TABLE_ENTRIES;
  localparam int MAXLEN  = DEF_MAX_LENGTH;
  localparam int TOPK    = DEF_TOP_LIMIT;

  typedef struct {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [SCORE_W-1:0] sim;
    logic              fin;
  } index_result_t;

  index_result_t      pending_results[$];
  logic               slot_used [ENTRIES];
  logic [ID_W-1:0]    slot_tag [ENTRIES];
  logic signed [15:0] slot_vec [ENTRIES][MAXLEN];
  logic signed [15:0] query_buf [MAXLEN];
  int                 elem_cnt;
  int                 req_len;

  function automatic logic [SCORE_W-1:0] cosine_score(input int s);
    int n;
    longint dot, na, nb, q, v;
    logic [127:0] prod, rhs, lhs;
    longint lo, hi, mid;
    n = elem_cnt;
    if (n > MAXLEN) n = MAXLEN;
    if (n > req_len) n = req_len;
    dot = 0; na = 0; nb = 0;
    for (int i = 0; i < n; i++) begin
      q = query_buf[i];
      v = slot_vec[s][i];
      dot += q * v;
      na += q * q;
      nb += v * v;
    end
    if (n == 0 || na < NORM_FLOOR || nb < NORM_FLOOR || dot <= 0) return '0;
    prod = 128'(na) * 128'(nb);
    rhs = (128'(dot) * 128'(dot)) << ROOT_SHIFT;
    lo = 0; hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = prod * 128'(mid * mid);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic index_result_t mk(input status_t st, input logic [ID_W-1:0] id,
                                       input logic [SCORE_W-1:0] sim, input logic fin);
    index_result_t r;
    r.status = st; r.id = id; r.sim = sim; r.fin = fin;
    return r;
  endfunction

  task automatic expect_result(input index_result_t r);
    pending_results = {pending_results, r};
  endtask

  task automatic run_search(input int limit);
    int cnt, p, lim;
    int rank_slot [ENTRIES];
    logic [SCORE_W-1:0] rank_score [ENTRIES];
    logic [SCORE_W-1:0] v;
    cnt = 0;
    for (int s = 0; s < ENTRIES; s++) begin
      if (slot_used[s]) begin
        v = cosine_score(s);
        if (v != 0) begin
          p = cnt;
          while (p > 0 && rank_score[p-1] < v) begin
            rank_score[p] = rank_score[p-1];
            rank_slot[p] = rank_slot[p-1];
            p--;
          end
          rank_score[p] = v;
          rank_slot[p] = s;
          cnt++;
        end
      end
    end
    lim = (limit > TOPK) ? TOPK : limit;
    if (lim > cnt) lim = cnt;
    if (lim == 0) expect_result(mk(STS_NO_HITS, '0, '0, 1'b1));
    for (int k = 0; k < lim; k++)
      expect_result(mk(STS_HIT, slot_tag[rank_slot[k]], rank_score[k], k == lim - 1));
  endtask

  task automatic run_add(input logic [ID_W-1:0] id);
    int slot;
    slot = ENTRIES;
    if (elem_cnt != req_len || elem_cnt > MAXLEN || elem_cnt == 0) begin
      expect_result(mk(STS_WRONG_LEN, id, '0, 1'b1));
      return;
    end
    for (int s = 0; s < ENTRIES; s++)
      if (slot == ENTRIES && slot_used[s] && slot_tag[s] == id) slot = s;
    for (int s = 0; s < ENTRIES; s++)
      if (slot == ENTRIES && !slot_used[s]) slot = s;
    if (slot == ENTRIES) begin
      expect_result(mk(STS_FULL, id, '0, 1'b1));
      return;
    end
    for (int i = 0; i < MAXLEN; i++)
      slot_vec[slot][i] = (i < elem_cnt) ? query_buf[i] : 16'sd0;
    slot_used[slot] = 1'b1;
    slot_tag[slot] = id;
    expect_result(mk(STS_ADDED, id, '0, 1'b1));
  endtask

  task automatic index_step();
    int hit;
    hit = -1;
    if (in_mode == MODE_REMOVE) begin
      for (int s = 0; s < ENTRIES; s++)
        if (hit < 0 && slot_used[s] && slot_tag[s] == in_entry_id) hit = s;
      if (hit >= 0) begin
        slot_used[hit] = 1'b0;
        expect_result(mk(STS_REMOVED, in_entry_id, '0, 1'b1));
      end else begin
        expect_result(mk(STS_NOT_FOUND, in_entry_id, '0, 1'b1));
      end
    end else if (in_mode == MODE_ADD || in_mode == MODE_SEARCH) begin
      if (elem_cnt < MAXLEN) query_buf[elem_cnt] = in_element_value;
      if (elem_cnt <= MAXLEN) elem_cnt++;
      if (in_last_element) begin
        if (in_mode == MODE_ADD) run_add(in_entry_id);
        else run_search(int'(in_result_limit));
        elem_cnt = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ENTRIES; s++) slot_used[s] = 1'b0;
      elem_cnt = 0;
      req_len = VLEN_RESET;
      pending_results.delete();
      errors = 0;
    end else begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("checker: unexpected result status=%0d id=%h sim=%0d fin=%0b",
                     out_status, out_result_id, out_similarity, out_final_result);
        end else begin
          index_result_t e;
          e = pending_results.pop_front();
          if (out_status !== e.status || out_result_id !== e.id ||
              out_similarity !== e.sim || out_final_result !== e.fin) begin
            errors++;
            if (errors <= 10)
              $display("checker: mismatch exp status=%0d id=%h sim=%0d fin=%0b,",
                       e.status, e.id, e.sim, e.fin,
                       " got status=%0d id=%h sim=%0d fin=%0b",
                       out_status, out_result_id, out_similarity, out_final_result);
          end
        end
      end
      if (cfg_we) req_len = int'(cfg_wdata);
      if (start && !busy) index_step();
    end
    pending = pending_results.size();
  end

endmodule

// ===== tb/sv/cosine_topk_vector_index_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_topk_vector_index_top_tb
// Drives add, remove and search transactions into the vector index over
// several vector length settings, directed corner cases first and random
// streams after, with random idle bursts; a checker module predicts and
// compares every result.
// ----------------------------------------------------------------------------
module cosine_topk_vector_index_top_tb;
  import ctvi_pkg::*;

  localparam longint     CYCLE_LIMIT = 4000000;
  localparam int         SETTLE      = 400;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_mode = MODE_ADD;
  logic [ID_W-1:0]     in_entry_id = '0;
  logic [ELEM_W-1:0]   in_element_value = '0;
  logic                in_last_element = 1'b0;
  logic [LIMIT_W-1:0]  in_result_limit = '0;
  logic                cfg_we = 1'b0;
  logic [VLEN_W-1:0]   cfg_wdata = '0;
  logic                out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_result_id;
  logic [SCORE_W-1:0]  out_similarity;
  logic                out_final_result;
  int                  errors;
  int                  pending;
  longint              cycles = 0;
  logic                calm = 1'b0;
  logic [ID_W-1:0]     id_pool [8];
  logic [ID_W-1:0]     fill_ids [65];
  logic [ELEM_W-1:0]   vec_buf [300];
  logic [ELEM_W-1:0]   base_vec [300];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cosine_topk_vector_index_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_entry_id(in_entry_id), .in_element_value(in_element_value),
    .in_last_element(in_last_element), .in_result_limit(in_result_limit),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_status(out_status), .out_result_id(out_result_id),
    .out_similarity(out_similarity), .out_final_result(out_final_result)
  );

  cosine_topk_vector_index_top_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_entry_id(in_entry_id), .in_element_value(in_element_value),
    .in_last_element(in_last_element), .in_result_limit(in_result_limit),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_status(out_status), .out_result_id(out_result_id),
    .out_similarity(out_similarity), .out_final_result(out_final_result),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cosine_topk_vector_index_top_tb: FAIL");
      $finish;
    end
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send(input logic [1:0] m, input logic [ID_W-1:0] id,
                      input logic [ELEM_W-1:0] e, input logic l,
                      input logic [LIMIT_W-1:0] lim);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        start = 1'b0;
        in_mode = 2'($urandom);
        in_entry_id = {$urandom, $urandom};
        in_element_value = 16'($urandom);
        in_last_element = 1'($urandom);
        in_result_limit = 5'($urandom);
        @(negedge clk);
      end
    end
    start = 1'b1;
    in_mode = m;
    in_entry_id = id;
    in_element_value = e;
    in_last_element = l;
    in_result_limit = lim;
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic stream(input logic [1:0] body_m, input logic [1:0] last_m,
                        input logic [ID_W-1:0] id, input int n,
                        input logic [LIMIT_W-1:0] lim);
    for (int i = 0; i < n - 1; i++)
      send(body_m, {$urandom, $urandom}, vec_buf[i], 1'b0, 5'($urandom));
    send(last_m, id, vec_buf[n-1], 1'b1, lim);
  endtask

  task automatic fill_rand(input int n);
    logic near;
    near = 1'($urandom);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: vec_buf[i] = 16'h8000;
        1: vec_buf[i] = 16'h7fff;
        2: vec_buf[i] = 16'($urandom_range(0, 7));
        default: vec_buf[i] = near ? base_vec[i] + 16'($urandom_range(0, 2047))
                                   : 16'($urandom);
      endcase
    end
  endtask

  task automatic wait_idle();
    while (pending != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_length(input int v);
    wait_idle();
    cfg_we = 1'b1;
    cfg_wdata = 9'(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return id_pool[r];
    return {$urandom, $urandom};
  endfunction

  task automatic random_op(input int vl);
    int r, n;
    r = $urandom_range(0, 19);
    if (r < 8) begin
      fill_rand(vl);
      stream(MODE_ADD, MODE_ADD, pick_id(), vl, 5'($urandom));
    end else if (r < 10) begin
      n = $urandom_range(1, vl + 2);
      fill_rand(n);
      stream(MODE_ADD, MODE_ADD, pick_id(), n, 5'($urandom));
    end else if (r < 13) begin
      send(MODE_REMOVE, pick_id(), 16'($urandom), 1'($urandom), 5'($urandom));
    end else if (r < 18) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, vl + 1) : vl;
      fill_rand(n);
      stream(MODE_SEARCH, MODE_SEARCH, {$urandom, $urandom}, n, 5'($urandom));
    end else if (r < 19) begin
      send(MODE_UNUSED, {$urandom, $urandom}, 16'($urandom), 1'($urandom), 5'($urandom));
    end else begin
      fill_rand(vl);
      if ($urandom_range(0, 1) == 0)
        stream(MODE_SEARCH, MODE_ADD, pick_id(), vl, 5'($urandom));
      else
        stream(MODE_ADD, MODE_SEARCH, pick_id(), vl, 5'($urandom));
    end
  endtask

  initial begin
    id_pool[0] = 64'h8000_0000_0000_0000;
    id_pool[1] = 64'h7fff_ffff_ffff_ffff;
    id_pool[2] = '0;
    id_pool[3] = '1;
    for (int i = 4; i < 8; i++) id_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < 65; i++) fill_ids[i] = {$urandom, 32'(i + 5000)};
    for (int i = 0; i < 300; i++) base_vec[i] = 16'($urandom);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    vec_buf[0] = 16'h4000;
    stream(MODE_SEARCH, MODE_SEARCH, '0, 1, 5'd5);
    send(MODE_REMOVE, id_pool[1], '0, 1'b0, '0);
    send(MODE_UNUSED, id_pool[2], 16'hffff, 1'b1, 5'd31);

    set_length(0);
    stream(MODE_ADD, MODE_ADD, id_pool[2], 1, '0);
    stream(MODE_SEARCH, MODE_SEARCH, '0, 1, 5'd3);
    set_length(511);
    stream(MODE_ADD, MODE_ADD, id_pool[3], 1, '0);

    set_length(1);
    for (int i = 0; i < 65; i++) begin
      vec_buf[0] = ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'($urandom_range(1, 32767));
      stream(MODE_ADD, MODE_ADD, fill_ids[i], 1, '0);
    end
    vec_buf[0] = 16'h7fff;
    stream(MODE_ADD, MODE_ADD, fill_ids[10], 1, '0);
    vec_buf[0] = 16'h4000;
    stream(MODE_SEARCH, MODE_SEARCH, '0, 1, 5'd31);
    stream(MODE_SEARCH, MODE_SEARCH, '0, 1, 5'd0);
    for (int i = 0; i < 5; i++)
      send(MODE_REMOVE, fill_ids[i], 16'($urandom), 1'($urandom), 5'($urandom));
    send(MODE_REMOVE, fill_ids[64], 16'($urandom), 1'($urandom), 5'($urandom));

    set_length(3);
    for (int i = 0; i < 3; i++) vec_buf[i] = 16'd1;
    stream(MODE_SEARCH, MODE_ADD, id_pool[5], 3, '0);
    stream(MODE_ADD, MODE_SEARCH, '0, 3, 5'd4);
    for (int i = 0; i < 3; i++) vec_buf[i] = 16'd20000;
    stream(MODE_SEARCH, MODE_SEARCH, '0, 3, 5'd4);

    for (int i = 0; i < 4; i++) random_op(3);
    calm = 1'b1;
    set_length(2);
    for (int i = 0; i < 4; i++) random_op(2);

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("cosine_topk_vector_index_top_tb: PASS");
    end else begin
      $display("cosine_topk_vector_index_top_tb: FAIL");
    end
    $finish;
  end

endmodule
